// ===== design/psff_pkg.sv =====
package psff_pkg;

  localparam int VALUE_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int GRID_LOG   = 5;
  localparam int IDX_W      = 3 * GRID_LOG;
  localparam int CELLS      = 1 << IDX_W;
  localparam int REG_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 3 * VALUE_W;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QLVL_W     = $clog2(QDEPTH + 1);

  localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_INV   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MU    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KAPPA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR  = 3'd4;

  typedef struct packed {
    logic                      opcode;
    logic [IDX_W-1:0]          idx;
    logic signed [VALUE_W-1:0] fc;
    logic signed [VALUE_W-1:0] fb;
    logic signed [VALUE_W-1:0] fa;
  } cmd_t;

  typedef struct packed {
    logic [REG_W-1:0]          inv;
    logic signed [VALUE_W-1:0] mu;
    logic [REG_W-1:0]          kappa;
    logic [REG_W-1:0]          mass;
    logic signed [VALUE_W-1:0] pair;
  } cfg_t;

  typedef struct packed {
    logic [QLVL_W-1:0] level;
    logic              pop;
  } qstat_t;

  typedef struct packed {
    logic busy;
    logic out_load;
  } bstat_t;

endpackage

// ===== design/psff_queue.sv =====
module psff_queue
  import psff_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  cmd_t   push_data,
  output logic   full,
  input  logic   pop,
  output logic   deq_valid,
  output cmd_t   deq_data,
  output qstat_t stat
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QLVL_W-1:0] level_r;

  assign full      = (level_r == QLVL_W'(QDEPTH));
  assign deq_valid = (level_r != '0);
  assign deq_data  = slot_r[rd_ptr_r];
  assign stat      = '{level: level_r, pop: pop};

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      level_r <= level_r + 1'b1;
      else if (pop && !push) level_r <= level_r - 1'b1;
    end
  end

endmodule

// ===== design/psff_back.sv =====
module psff_back
  import psff_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  output logic                  cmd_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  output bstat_t                stat
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_MULG = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_MULF = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  // global product steps
  localparam logic [2:0] G_M2 = 3'd0;
  localparam logic [2:0] G_T1 = 3'd1;
  localparam logic [2:0] G_PR = 3'd2;
  localparam logic [2:0] G_PP = 3'd3;
  localparam logic [2:0] G_KP = 3'd4;
  localparam logic [2:0] G_DD = 3'd5;
  localparam logic [2:0] G_MP = 3'd6;
  // per-field product steps
  localparam logic [2:0] F_LAP = 3'd0;
  localparam logic [2:0] F_Q   = 3'd1;
  localparam logic [2:0] F_FT  = 3'd2;
  localparam logic [2:0] F_FPW = 3'd3;
  localparam logic [2:0] F_MC  = 3'd4;

  localparam logic [2:0] READ_LAST = 3'd7;
  localparam logic [1:0] FA_LAST   = 2'd2;
  localparam int         DIV_W     = VALUE_W + FRAC_BITS;
  localparam logic [5:0] DIV_LAST  = 6'(DIV_W - 1);
  localparam int         SUM_W     = VALUE_W + 4;
  localparam int         VW        = VALUE_W;

  state_t state_r, state_nxt;

  logic [3*VW-1:0] mem [CELLS];
  logic [3*VW-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  logic [IDX_W-1:0]    idx_r;
  logic [2:0]          rd_cnt_r, step_r, sub_r;
  logic [1:0]          fa_r;
  logic                mph_r;
  logic signed [VW-1:0]    p_r [3];
  logic signed [SUM_W-1:0] sum_r [3];
  logic signed [VW-1:0]    acc_r [3];
  logic signed [2*VW-1:0]  prod_r;
  logic signed [VW-1:0] m2_r, t1_r, pr_r, pp_r, kp_r, dd_r, g_r, lap_r, q_r, ft_r, fpw_r;
  logic                 ov_r;
  logic [DIV_W-1:0]     dx_r, dq_r;
  logic [VW-1:0]        rem_r;
  logic [5:0]           dcnt_r;
  logic                 dneg_r;
  logic                 out_valid_r, out_ov_r;
  logic [3*VW-1:0]      out_data_r;

  logic [GRID_LOG-1:0] ci, cj, ck;
  logic signed [VW-1:0] opa, opb, mres, den, lap_in, s12, fin;
  logic signed [VW:0]   den_sum, s12_sum;
  logic signed [VW+1:0] fin_sum;
  logic                 mov, den_ov, lap_ov, s12_ov, fin_ov, issue_ov;
  logic [2*VW-FRAC_BITS-VW:0] mtop;
  logic [VW-1:0]        t_div, mp_mag;
  logic                 ge;
  logic [DIV_W-1:0]     q_fin;
  logic signed [VW-1:0] g_val;
  logic                 g_ov, out_free, load_out;

  // field store, one word holds all three fields of a point
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.idx] <= {cmd.fc, cmd.fb, cmd.fa};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid;
  assign mem_we  = cmd_pop && (cmd.opcode == OP_LOAD);

  assign ci = idx_r[IDX_W-1 -: GRID_LOG];
  assign cj = idx_r[2*GRID_LOG-1 -: GRID_LOG];
  assign ck = idx_r[GRID_LOG-1:0];

  // centre, then the six neighbours with periodic wrap
  always_comb begin
    case (rd_cnt_r)
      3'd1:    rd_addr = {ci + 1'b1, cj, ck};
      3'd2:    rd_addr = {ci - 1'b1, cj, ck};
      3'd3:    rd_addr = {ci, cj + 1'b1, ck};
      3'd4:    rd_addr = {ci, cj - 1'b1, ck};
      3'd5:    rd_addr = {ci, cj, ck + 1'b1};
      3'd6:    rd_addr = {ci, cj, ck - 1'b1};
      default: rd_addr = idx_r;
    endcase
  end

  // saturating helpers
  assign den_sum = {kp_r[VW-1], kp_r} + (VW+1)'(1 << FRAC_BITS);
  assign den_ov  = den_sum[VW] != den_sum[VW-1];
  assign den     = den_ov ? (den_sum[VW] ? VMIN : VMAX) : den_sum[VW-1:0];

  assign lap_ov = !((&sum_r[0][SUM_W-1:VW-1]) || !(|sum_r[0][SUM_W-1:VW-1]));
  assign lap_in = lap_ov ? (sum_r[0][SUM_W-1] ? VMIN : VMAX) : sum_r[0][VW-1:0];

  assign s12_sum = {p_r[1][VW-1], p_r[1]} + {p_r[2][VW-1], p_r[2]};
  assign s12_ov  = s12_sum[VW] != s12_sum[VW-1];
  assign s12     = s12_ov ? (s12_sum[VW] ? VMIN : VMAX) : s12_sum[VW-1:0];

  // multiplier operands
  always_comb begin
    opa      = '0;
    opb      = '0;
    issue_ov = 1'b0;
    if (state_r == ST_MULG) begin
      case (step_r)
        G_M2:    begin opa = {1'b0, cfg.mass};  opb = {1'b0, cfg.mass}; end
        G_T1:    begin opa = p_r[0];            opb = p_r[1]; end
        G_PR:    begin opa = t1_r;              opb = p_r[2]; end
        G_PP:    begin opa = pr_r;              opb = pr_r; end
        G_KP:    begin opa = {1'b0, cfg.kappa}; opb = pp_r; end
        G_DD:    begin opa = den; opb = den; issue_ov = den_ov; end
        G_MP:    begin opa = cfg.mu;            opb = pr_r; end
        default: begin opa = '0;                opb = '0; end
      endcase
    end else begin
      case (sub_r)
        F_LAP:   begin opa = lap_in; opb = {1'b0, cfg.inv}; issue_ov = lap_ov; end
        F_Q:     begin opa = p_r[1]; opb = p_r[2]; end
        F_FT:    begin opa = g_r;    opb = q_r; end
        F_FPW:   begin opa = cfg.pair; opb = s12; issue_ov = s12_ov; end
        F_MC:    begin opa = m2_r;   opb = p_r[0]; end
        default: begin opa = '0;     opb = '0; end
      endcase
    end
  end

  // product shifted by the fraction bits and saturated
  assign mtop = prod_r[2*VW-1:FRAC_BITS+VW-1];
  assign mov  = !((&mtop) || !(|mtop));
  assign mres = mov ? (prod_r[2*VW-1] ? VMIN : VMAX) : prod_r[FRAC_BITS+VW-1:FRAC_BITS];

  assign fin_sum = {{2{lap_r[VW-1]}}, lap_r} - {{2{mres[VW-1]}}, mres}
                 - {{2{ft_r[VW-1]}}, ft_r} - {{2{fpw_r[VW-1]}}, fpw_r};
  assign fin_ov  = !((&fin_sum[VW+1:VW-1]) || !(|fin_sum[VW+1:VW-1]));
  assign fin     = fin_ov ? (fin_sum[VW+1] ? VMIN : VMAX) : fin_sum[VW-1:0];

  // restoring divider, one quotient bit per cycle
  assign mp_mag = mres[VW-1] ? (~mres + 1'b1) : mres;
  assign t_div  = {rem_r[VW-2:0], dx_r[DIV_W-1]};
  assign ge     = t_div >= dd_r;
  assign q_fin  = {dq_r[DIV_W-2:0], ge};
  always_comb begin
    g_ov  = 1'b0;
    g_val = q_fin[VW-1:0];
    if (dneg_r) begin
      if ((q_fin[DIV_W-1:VW-1] == '0) ||
          ((q_fin[DIV_W-1:VW] == '0) && (q_fin[VW-1:0] == VMIN))) begin
        g_val = ~q_fin[VW-1:0] + 1'b1;
      end else begin
        g_val = VMIN;
        g_ov  = 1'b1;
      end
    end else if (q_fin[DIV_W-1:VW-1] != '0) begin
      g_val = VMAX;
      g_ov  = 1'b1;
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign load_out = (state_r == ST_DONE) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (cmd_valid && cmd.opcode == OP_COMPUTE) state_nxt = ST_READ;
      ST_READ: if (rd_cnt_r == READ_LAST) state_nxt = ST_MULG;
      ST_MULG: if (mph_r && step_r == G_MP) state_nxt = ST_DIV;
      ST_DIV:  if (dcnt_r == DIV_LAST) state_nxt = ST_MULF;
      ST_MULF: if (mph_r && sub_r == F_MC && fa_r == FA_LAST) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_cnt_r    <= '0;
      step_r      <= '0;
      sub_r       <= '0;
      fa_r        <= '0;
      mph_r       <= 1'b0;
      dcnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          rd_cnt_r <= '0;
          step_r   <= '0;
          sub_r    <= '0;
          fa_r     <= '0;
          mph_r    <= 1'b0;
          dcnt_r   <= '0;
        end
        ST_READ: rd_cnt_r <= rd_cnt_r + 1'b1;
        ST_MULG: begin
          mph_r <= !mph_r;
          if (mph_r) step_r <= step_r + 1'b1;
        end
        ST_DIV: dcnt_r <= dcnt_r + 1'b1;
        ST_MULF: begin
          mph_r <= !mph_r;
          if (mph_r) begin
            if (sub_r == F_MC) begin
              sub_r <= '0;
              fa_r  <= fa_r + 1'b1;
            end else begin
              sub_r <= sub_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        idx_r <= cmd.idx;
        ov_r  <= 1'b0;
      end
      ST_READ: begin
        if (rd_cnt_r != '0) begin
          for (int f = 0; f < 3; f++) begin
            if (rd_cnt_r == 3'd1) begin
              p_r[f]   <= rd_data_r[f*VW +: VW];
              sum_r[f] <= -((SUM_W'(signed'(rd_data_r[f*VW +: VW])) <<< 2)
                          + (SUM_W'(signed'(rd_data_r[f*VW +: VW])) <<< 1));
            end else begin
              sum_r[f] <= sum_r[f] + SUM_W'(signed'(rd_data_r[f*VW +: VW]));
            end
          end
        end
      end
      ST_MULG: begin
        if (!mph_r) begin
          prod_r <= opa * opb;
          ov_r   <= ov_r | issue_ov;
        end else begin
          ov_r <= ov_r | mov;
          case (step_r)
            G_M2: m2_r <= mres;
            G_T1: t1_r <= mres;
            G_PR: pr_r <= mres;
            G_PP: pp_r <= mres;
            G_KP: kp_r <= mres;
            G_DD: dd_r <= (mres == '0) ? VW'(1) : mres;
            G_MP: begin
              dneg_r <= mres[VW-1];
              dx_r   <= {mp_mag, {FRAC_BITS{1'b0}}};
              rem_r  <= '0;
              dq_r   <= '0;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        rem_r <= ge ? (t_div - dd_r) : t_div;
        dq_r  <= q_fin;
        dx_r  <= dx_r << 1;
        if (dcnt_r == DIV_LAST) begin
          g_r  <= g_val;
          ov_r <= ov_r | g_ov;
        end
      end
      ST_MULF: begin
        if (!mph_r) begin
          prod_r <= opa * opb;
          ov_r   <= ov_r | issue_ov;
        end else begin
          case (sub_r)
            F_LAP: begin lap_r <= mres; ov_r <= ov_r | mov; end
            F_Q:   begin q_r   <= mres; ov_r <= ov_r | mov; end
            F_FT:  begin ft_r  <= mres; ov_r <= ov_r | mov; end
            F_FPW: begin fpw_r <= mres; ov_r <= ov_r | mov; end
            F_MC: begin
              ov_r     <= ov_r | mov | fin_ov;
              acc_r[0] <= acc_r[1];
              acc_r[1] <= acc_r[2];
              acc_r[2] <= fin;
              // rotate so the next field sits in slot zero
              p_r[0]   <= p_r[1];
              p_r[1]   <= p_r[2];
              p_r[2]   <= p_r[0];
              sum_r[0] <= sum_r[1];
              sum_r[1] <= sum_r[2];
              sum_r[2] <= sum_r[0];
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_data_r <= {acc_r[2], acc_r[1], acc_r[0]};
      out_ov_r   <= ov_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ov_r;
  assign stat       = '{busy: (state_r != ST_IDLE), out_load: load_out};

endmodule

// ===== design/periodic_stencil_field_force_top.sv =====
// channel | dir | handshake              | payload
// in      | in  | in_tvalid / in_tready   | tuser opcode; tdata point index, fields a, b, c
// out     | out | out_tvalid / out_tready | tuser overflow; tdata accel a, b, c
// cfg     | in  | cfg_valid / cfg_ready   | cfg_index register, cfg_data value
//
// a load item writes the store when it is popped. a compute item reads the seven stencil points
// from the field memory, then runs 22 products through one shared 32x32 multiplier, with the
// bit-serial divider between the global and the per-field products, then hands off its result.
// a four-entry command queue lets the input keep accepting while the back end works.
// rst_n is synchronous; it resets control state and the config registers, not the store.
// the result register holds its beat until taken; the back end stalls only when a new
// result is ready and the previous one is still waiting.
module periodic_stencil_field_force_top
  import psff_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // point_index, field_a, field_b, field_c, pad
  input  logic                  in_tuser,   // opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // accel_a, accel_b, accel_c
  output logic                  out_tuser,  // overflow
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [VALUE_W-1:0]    cfg_data
);

  cfg_t   cfg_r;
  cmd_t   in_cmd, q_cmd;
  logic   q_full, q_valid, q_pop, push;
  qstat_t q_stat;
  bstat_t b_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv   <= REG_W'(1 << FRAC_BITS);
      cfg_r.mu    <= '0;
      cfg_r.kappa <= '0;
      cfg_r.mass  <= REG_W'(1 << FRAC_BITS);
      cfg_r.pair  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INV:   cfg_r.inv   <= cfg_data[REG_W-1:0];
        REG_MU:    cfg_r.mu    <= cfg_data;
        REG_KAPPA: cfg_r.kappa <= cfg_data[REG_W-1:0];
        REG_MASS:  cfg_r.mass  <= cfg_data[REG_W-1:0];
        REG_PAIR:  cfg_r.pair  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: unpack and classify the beat
  assign in_cmd.opcode = in_tuser;
  assign in_cmd.idx    = in_tdata[IDX_W-1:0];
  assign in_cmd.fa     = in_tdata[IDX_W +: VALUE_W];
  assign in_cmd.fb     = in_tdata[IDX_W+VALUE_W +: VALUE_W];
  assign in_cmd.fc     = in_tdata[IDX_W+2*VALUE_W +: VALUE_W];

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  psff_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (in_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .deq_valid (q_valid),
    .deq_data  (q_cmd),
    .stat      (q_stat)
  );

  psff_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd_valid  (q_valid),
    .cmd        (q_cmd),
    .cmd_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .stat       (b_stat)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.pop |-> (q_stat.level != '0))
    else $error("queue popped while empty");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= QLVL_W'(QDEPTH))
    else $error("queue level beyond depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    b_stat.out_load |-> !(out_tvalid && !out_tready))
    else $error("result register overwritten before taken");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.pop |-> !b_stat.busy)
    else $error("back end took a command while busy");
`endif

endmodule

// ===== tb/periodic_stencil_field_force_top_tb.sv =====
`default_nettype none

module periodic_stencil_field_force_top_tb;
  import psff_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [31:0] acc_a;
    logic [31:0] acc_b;
    logic [31:0] acc_c;
    logic        ovf;
  } accel_t;

  typedef struct {
    logic        op;
    int          idx;
    logic [31:0] fa;
    logic [31:0] fb;
    logic [31:0] fc;
    bit          typed;
    accel_t      want;
  } stim_row_t;

  localparam longint VMX = 64'sd2147483647;
  localparam longint VMN = -64'sd2147483648;
  localparam int     SIDE = 1 << GRID_LOG;
  localparam int     ITEMS_PER_PHASE = 120;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [VALUE_W-1:0]    cfg_data;

  periodic_stencil_field_force_top dut (.*);

  // predictor state
  longint field_a_q [CELLS];
  longint field_b_q [CELLS];
  longint field_c_q [CELLS];
  bit     loaded_q  [CELLS];
  longint inv_sq, mu, kappa, mass, pair;
  bit     sat_flag;

  accel_t accel_q[$];
  int     n_errors;
  int     n_results;
  int     n_items;
  int     n_ovf;
  int     burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("FAIL periodic_stencil_field_force_top");
    $finish;
  end

  function automatic longint sat_val(wide_t x);
    if (x > wide_t'(VMX)) begin
      sat_flag = 1'b1;
      return VMX;
    end
    if (x < wide_t'(VMN)) begin
      sat_flag = 1'b1;
      return VMN;
    end
    return longint'(x);
  endfunction

  function automatic longint qmul(longint a, longint b);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    return sat_val(p >>> FRAC_BITS);
  endfunction

  function automatic longint qdiv(longint num, longint den);
    wide_t m, q;
    m = (num < 0) ? -wide_t'(num) : wide_t'(num);
    q = (m <<< FRAC_BITS) / wide_t'(den);
    if (num < 0) q = -q;
    return sat_val(q);
  endfunction

  function automatic accel_t predict_accel(int idx);
    accel_t r;
    longint p[3], nbv[3][6], m2, pr, pp, den, dd, g, lap, ft, fpw, acc;
    int i, j, k, nb[6];
    wide_t sum;
    sat_flag = 1'b0;
    i = idx / (SIDE * SIDE);
    j = (idx / SIDE) % SIDE;
    k = idx % SIDE;
    nb[0] = ((i + 1) % SIDE) * SIDE * SIDE + j * SIDE + k;
    nb[1] = ((i + SIDE - 1) % SIDE) * SIDE * SIDE + j * SIDE + k;
    nb[2] = i * SIDE * SIDE + ((j + 1) % SIDE) * SIDE + k;
    nb[3] = i * SIDE * SIDE + ((j + SIDE - 1) % SIDE) * SIDE + k;
    nb[4] = i * SIDE * SIDE + j * SIDE + (k + 1) % SIDE;
    nb[5] = i * SIDE * SIDE + j * SIDE + (k + SIDE - 1) % SIDE;
    p[0] = field_a_q[idx];
    p[1] = field_b_q[idx];
    p[2] = field_c_q[idx];
    for (int n = 0; n < 6; n++) begin
      nbv[0][n] = field_a_q[nb[n]];
      nbv[1][n] = field_b_q[nb[n]];
      nbv[2][n] = field_c_q[nb[n]];
    end
    m2  = qmul(mass, mass);
    pr  = qmul(qmul(p[0], p[1]), p[2]);
    pp  = qmul(pr, pr);
    den = sat_val(wide_t'(64'sd1 <<< FRAC_BITS) + wide_t'(qmul(kappa, pp)));
    dd  = qmul(den, den);
    if (dd < 1) dd = 1;
    g = qdiv(qmul(mu, pr), dd);
    for (int f = 0; f < 3; f++) begin
      sum = wide_t'(p[f]) * -6;
      for (int n = 0; n < 6; n++) sum = sum + wide_t'(nbv[f][n]);
      lap = qmul(sat_val(sum), inv_sq);
      ft  = qmul(g, qmul(p[(f + 1) % 3], p[(f + 2) % 3]));
      fpw = qmul(pair, sat_val(wide_t'(p[(f + 1) % 3]) + wide_t'(p[(f + 2) % 3])));
      acc = sat_val(wide_t'(lap) - wide_t'(qmul(m2, p[f])) - wide_t'(ft) - wide_t'(fpw));
      case (f)
        0: r.acc_a = acc[31:0];
        1: r.acc_b = acc[31:0];
        default: r.acc_c = acc[31:0];
      endcase
    end
    r.ovf = sat_flag;
    return r;
  endfunction

  // one input beat; keeps tvalid high inside a burst
  task automatic send_item(logic op, int idx, logic [31:0] fa, logic [31:0] fb,
                           logic [31:0] fc, bit typed, accel_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, fc, fb, fa, idx[IDX_W-1:0]};
    do @(posedge clk); while (!in_tready);
    n_items++;
    if (op == OP_LOAD) begin
      field_a_q[idx] = longint'(signed'(fa));
      field_b_q[idx] = longint'(signed'(fb));
      field_c_q[idx] = longint'(signed'(fc));
      loaded_q[idx]  = 1'b1;
    end else if (typed) begin
      accel_q.push_back(want);
    end else begin
      accel_q.push_back(predict_accel(idx));
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 524288) - 262144;
      4, 5:       return $urandom_range(0, 65536) - 32768;
      6:          return $urandom;
      7:          return VMAX;
      8:          return VMIN;
      default:    return '0;
    endcase
  endfunction

  task automatic load_random(int idx);
    accel_t none;
    none = '{default: '0};
    send_item(OP_LOAD, idx, pick_value(), pick_value(), pick_value(), 1'b0, none);
  endtask

  // loads any of the seven stencil points still unwritten, then computes
  task automatic compute_at(int idx);
    int i, j, k, pts[7];
    accel_t none;
    none = '{default: '0};
    i = idx / (SIDE * SIDE);
    j = (idx / SIDE) % SIDE;
    k = idx % SIDE;
    pts[0] = idx;
    pts[1] = ((i + 1) % SIDE) * SIDE * SIDE + j * SIDE + k;
    pts[2] = ((i + SIDE - 1) % SIDE) * SIDE * SIDE + j * SIDE + k;
    pts[3] = i * SIDE * SIDE + ((j + 1) % SIDE) * SIDE + k;
    pts[4] = i * SIDE * SIDE + ((j + SIDE - 1) % SIDE) * SIDE + k;
    pts[5] = i * SIDE * SIDE + j * SIDE + (k + 1) % SIDE;
    pts[6] = i * SIDE * SIDE + j * SIDE + (k + SIDE - 1) % SIDE;
    foreach (pts[n]) if (!loaded_q[pts[n]]) load_random(pts[n]);
    send_item(OP_COMPUTE, idx, $urandom, $urandom, $urandom, 1'b0, none);
  endtask

  task automatic write_regs(logic [31:0] v_inv, logic [31:0] v_mu, logic [31:0] v_kappa,
                            logic [31:0] v_mass, logic [31:0] v_pair);
    logic [31:0] vals[5];
    logic [CFG_IDX_W-1:0] regs[5];
    vals = '{v_inv, v_mu, v_kappa, v_mass, v_pair};
    regs = '{REG_INV, REG_MU, REG_KAPPA, REG_MASS, REG_PAIR};
    foreach (regs[r]) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    inv_sq = longint'(v_inv[30:0]);
    mu     = longint'(signed'(v_mu));
    kappa  = longint'(v_kappa[30:0]);
    mass   = longint'(v_mass[30:0]);
    pair   = longint'(signed'(v_pair));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    wait (accel_q.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
    n_errors++;
  endtask

  // receiver: rotating ready pattern, reshuffled now and then
  logic [15:0] ready_pat;
  int          pat_age;

  always @(posedge clk) begin
    accel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (accel_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[31:0], '0);
      end else begin
        want = accel_q.pop_front();
        if (out_tdata[31:0] !== want.acc_a)
          report_mismatch("accel_a", out_tdata[31:0], want.acc_a);
        if (out_tdata[63:32] !== want.acc_b)
          report_mismatch("accel_b", out_tdata[63:32], want.acc_b);
        if (out_tdata[95:64] !== want.acc_c)
          report_mismatch("accel_c", out_tdata[95:64], want.acc_c);
        if (out_tuser !== want.ovf)
          report_mismatch("overflow", 32'(out_tuser), 32'(want.ovf));
        if (want.ovf) n_ovf++;
      end
      n_results++;
    end
    if (pat_age == 0) begin
      ready_pat <= ($urandom_range(0, 2) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
      pat_age   <= $urandom_range(50, 400);
      out_tready <= 1'b1;
    end else begin
      ready_pat  <= {ready_pat[0], ready_pat[15:1]};
      pat_age    <= pat_age - 1;
      out_tready <= ready_pat[0];
    end
  end

  initial begin
    stim_row_t rows[$];
    accel_t zero_acc, none;
    int zero_pts[7];
    int idx, pick[5];
    int phase_end;
    zero_acc = '{default: '0};
    none     = '{default: '0};
    zero_pts = '{0, 1024, 31744, 32, 992, 1, 31};
    pick     = '{30, 31, 0, 1, 2};

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_LOAD;
    cfg_valid  = 1'b0;
    cfg_index  = REG_INV;
    cfg_data   = '0;
    out_tready = 1'b0;
    ready_pat  = 16'hffff;
    pat_age    = 0;
    n_errors   = 0;
    n_results  = 0;
    n_items    = 0;
    n_ovf      = 0;
    burst_left = 0;
    inv_sq = 65536; mu = 0; kappa = 0; mass = 65536; pair = 0;
    foreach (loaded_q[n]) begin
      loaded_q[n]  = 1'b0;
      field_a_q[n] = 0;
      field_b_q[n] = 0;
      field_c_q[n] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: zero field gives zero, a pinned centre saturates the laplacian
    foreach (zero_pts[n]) rows.push_back('{OP_LOAD, zero_pts[n], 0, 0, 0, 1'b0, none});
    rows.push_back('{OP_COMPUTE, 0, 0, 0, 0, 1'b1, zero_acc});
    rows.push_back('{OP_LOAD, 0, VMAX, 0, 0, 1'b0, none});
    rows.push_back('{OP_COMPUTE, 0, 0, 0, 0, 1'b1, '{VMIN, 0, 0, 1'b1}});
    rows.push_back('{OP_LOAD, 0, VMIN, 0, 0, 1'b0, none});
    rows.push_back('{OP_COMPUTE, 0, 0, 0, 0, 1'b1, '{VMAX, 0, 0, 1'b1}});
    rows.push_back('{OP_LOAD, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, none});
    rows.push_back('{OP_COMPUTE, 0, 0, 0, 0, 1'b0, none});
    rows.push_back('{OP_LOAD, 1, 32'hfffe_0000, VMAX, VMIN, 1'b0, none});
    rows.push_back('{OP_COMPUTE, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, none});
    rows.push_back('{OP_LOAD, 0, VMAX, VMAX, VMAX, 1'b0, none});
    rows.push_back('{OP_COMPUTE, 0, 0, 0, 0, 1'b0, none});
    foreach (rows[r])
      send_item(rows[r].op, rows[r].idx, rows[r].fa, rows[r].fb, rows[r].fc,
                rows[r].typed, rows[r].want);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                      32'h0000_8000);
        1: write_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h8000_0000);
        2: write_regs(0, 0, 0, 0, 0);
        3: write_regs($urandom_range(0, 262144), $urandom_range(0, 524288) - 262144,
                      $urandom_range(0, 131072), $urandom_range(0, 131072),
                      $urandom_range(0, 131072) - 65536);
        default: write_regs($urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      phase_end = n_items + ITEMS_PER_PHASE;
      while (n_items < phase_end) begin
        if ($urandom_range(0, 9) < 3) begin
          load_random($urandom_range(0, CELLS - 1));
        end else begin
          if ($urandom_range(0, 3) != 0)
            idx = pick[$urandom_range(0, 4)] * SIDE * SIDE
                + pick[$urandom_range(0, 4)] * SIDE + pick[$urandom_range(0, 4)];
          else
            idx = $urandom_range(0, CELLS - 1);
          compute_at(idx);
        end
      end
      drain();
    end

    $display("%0d items sent, %0d results checked, %0d with overflow, 6 register settings",
             n_items, n_results, n_ovf);
    if (n_errors == 0) begin
      $display("PASS periodic_stencil_field_force_top");
    end else begin
      $display("FAIL periodic_stencil_field_force_top");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== periodic_stencil_field_force_top.f =====
design/psff_pkg.sv
design/psff_queue.sv
design/psff_back.sv
design/periodic_stencil_field_force_top.sv
tb/periodic_stencil_field_force_top_tb.sv
